### rtl/gpt_pkg.sv
// ----------------------------------------------------------------------------
// gpt_pkg
// Shared types and constants of the general purpose timer register block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpt_pkg;

  // item opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SECURE_LOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_EN    = 2'd1;

  // register byte offsets
  localparam logic [9:0] OFS_CR1  = 10'h000;
  localparam logic [9:0] OFS_DIER = 10'h00C;
  localparam logic [9:0] OFS_SR   = 10'h010;
  localparam logic [9:0] OFS_EGR  = 10'h014;
  localparam logic [9:0] OFS_CNT  = 10'h024;
  localparam logic [9:0] OFS_PSC  = 10'h028;
  localparam logic [9:0] OFS_ARR  = 10'h02C;

  // register bit positions
  localparam int unsigned BIT_CEN  = 0;
  localparam int unsigned BIT_UDIS = 1;
  localparam int unsigned BIT_OPM  = 3;
  localparam int unsigned BIT_DIR  = 4;
  localparam int unsigned BIT_UIE  = 0;
  localparam int unsigned BIT_UG   = 0;

  localparam int unsigned HALF_W = 16;

  // shared divider width: 16-bit accumulator plus 32-bit cycle count
  localparam int unsigned DIV_W     = 33;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  typedef enum logic [2:0] {
    REG_CR1,
    REG_DIER,
    REG_SR,
    REG_EGR,
    REG_CNT,
    REG_PSC,
    REG_ARR
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRESCALE,
    ST_ADVANCE,
    ST_WRAP,
    ST_DONE
  } state_e;

  // decoded bus access
  typedef struct packed {
    logic        hit;
    reg_e        sel;
    logic [1:0]  pos;
    logic [31:0] mask;
    logic [31:0] lane;
  } acc_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/gpt_div.sv
// ----------------------------------------------------------------------------
// gpt_div
// Restoring divider, one quotient bit per cycle, shared by the prescaler
// division and the wrap modulo.
// ----------------------------------------------------------------------------
`default_nettype none

module gpt_div
  import gpt_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     dsr_q, dsr_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [DIV_W:0]   rem_sh;
  logic [DIV_W+1:0] sub;
  logic             ge;

  // trial subtract of the shifted partial remainder
  assign rem_sh = {rem_q, quo_q[DIV_W-1]};
  assign sub    = {1'b0, rem_sh} - {2'b00, dsr_q};
  assign ge     = ~sub[DIV_W+1];

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = DIV_CNT_W'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o = '{done: done_q, quotient: quo_q, remainder: rem_q};

endmodule

`default_nettype wire

### rtl/gpt_bus_dec.sv
// ----------------------------------------------------------------------------
// gpt_bus_dec
// Bus access decoder: register select, byte position, size and lane masks.
// ----------------------------------------------------------------------------
`default_nettype none

module gpt_bus_dec
  import gpt_pkg::*;
(
  input  wire [9:0] offset_i,
  input  wire [2:0] size_i,
  output acc_t      acc_o
);

  logic        word_hit;
  logic [3:0]  end_pos;
  reg_e        sel;
  logic [31:0] mask;

  // register select by word address
  always_comb begin
    word_hit = 1'b1;
    sel      = REG_CR1;
    case (offset_i[9:2])
      OFS_CR1[9:2]:  sel      = REG_CR1;
      OFS_DIER[9:2]: sel      = REG_DIER;
      OFS_SR[9:2]:   sel      = REG_SR;
      OFS_EGR[9:2]:  sel      = REG_EGR;
      OFS_CNT[9:2]:  sel      = REG_CNT;
      OFS_PSC[9:2]:  sel      = REG_PSC;
      OFS_ARR[9:2]:  sel      = REG_ARR;
      default:       word_hit = 1'b0;
    endcase
  end

  // access must not run past the end of its register
  assign end_pos = {2'b00, offset_i[1:0]} + {1'b0, size_i};

  // byte mask of the access size
  always_comb begin
    case (size_i)
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end

  assign acc_o = '{hit:  word_hit && (end_pos <= 4'd4),
                   sel:  sel,
                   pos:  offset_i[1:0],
                   mask: mask,
                   lane: mask << {offset_i[1:0], 3'b000}};

endmodule

`default_nettype wire

### rtl/general_purpose_timer_regs.sv
// Read, write and stopped-tick words: result register one cycle after acceptance.
// Running ticks: prescaler division, plus a modulo on a wrap, in the shared
// 33-step divider; states prescale, advance and, on a wrap, wrap, then the done state.
// Next word taken the cycle after the result register loads; a held output delays it.
// Reset: CR1, DIER, SR, CNT, PSC and the accumulator clear, ARR is all ones, the
// secure lock clears and clock enable sets. No clearing pass.
// ----------------------------------------------------------------------------
// general_purpose_timer_regs
// Timer with prescaler and auto-reload up/down counter behind a register
// window, driven by tick words and bus read and write words.
// ----------------------------------------------------------------------------
`default_nettype none

module general_purpose_timer_regs
  import gpt_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // input words
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire [1:0]            op_i,
  input  wire [9:0]            offset_i,
  input  wire [2:0]            size_bytes_i,
  input  wire [31:0]           wdata_i,
  input  wire [31:0]           cycles_i,
  input  wire                  nonsecure_i,
  // result words
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [31:0]          rdata_o,
  output logic                 bus_error_o,
  output logic                 irq_pulse_o,
  output logic                 update_flag_o,
  // configuration writes
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CW = COUNTER_WIDTH;

  state_e state_q, state_d;

  logic          secure_q, clken_q;
  logic [15:0]   ctrl_q, ctrl_d;
  logic [15:0]   dier_q, dier_d;
  logic          uif_q, uif_d;
  logic [CW-1:0] counter_q, counter_d;
  logic [15:0]   psc_q, psc_d;
  logic [CW-1:0] reload_q, reload_d;
  logic [15:0]   accum_q, accum_d;

  // per-tick working registers
  logic [CW-1:0]    cnt_clamp_q, cnt_clamp_d;
  logic [CW:0]      thr_q, thr_d;
  logic [DIV_W-1:0] ticks_q, ticks_d;

  // pending result
  logic [31:0] res_rdata_q, res_rdata_d;
  logic        res_berr_q, res_berr_d;
  logic        res_irq_q, res_irq_d;

  // output register
  logic        out_valid_q;
  logic [31:0] out_rdata_q;
  logic        out_berr_q, out_irq_q, out_uif_q;

  div_req_t div_req;
  div_rsp_t div_rsp;
  acc_t     acc;

  logic accept, out_free, blocked, size_ok, tick_run;
  logic [CW-1:0]    cnt_clamp;
  logic [CW:0]      period;
  logic [DIV_W-1:0] thr_ext;
  logic             wrap_ge;
  logic [DIV_W-1:0] wrap_diff;
  logic [31:0]      cur32, rd32, merged32;

  gpt_bus_dec u_dec (
    .offset_i (offset_i),
    .size_i   (size_bytes_i),
    .acc_o    (acc)
  );

  gpt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign blocked     = secure_q && nonsecure_i;
  assign size_ok     = (size_bytes_i != 3'd0) && (size_bytes_i <= 3'd4);
  assign tick_run    = ctrl_q[BIT_CEN] && clken_q;
  assign cfg_ready_o = 1'b1;

  // counter above reload is treated as reload
  assign cnt_clamp = (counter_q > reload_q) ? reload_q : counter_q;
  assign period    = {1'b0, reload_q} + 1'b1;

  // wrap test on the prescaled tick count
  assign thr_ext   = DIV_W'(thr_q);
  assign wrap_ge   = (ticks_q >= thr_ext);
  assign wrap_diff = ticks_q - thr_ext;

  // current register value, read slice and write merge
  always_comb begin
    case (acc.sel)
      REG_CR1:  cur32 = 32'(ctrl_q);
      REG_DIER: cur32 = 32'(dier_q);
      REG_SR:   cur32 = 32'(uif_q);
      REG_CNT:  cur32 = 32'(counter_q);
      REG_PSC:  cur32 = 32'(psc_q);
      REG_ARR:  cur32 = 32'(reload_q);
      default:  cur32 = '0;
    endcase
  end

  assign rd32     = (cur32 >> {acc.pos, 3'b000}) & acc.mask;
  assign merged32 = (cur32 & ~acc.lane) | ((wdata_i & acc.mask) << {acc.pos, 3'b000});

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (op_i == OP_TICK && tick_run) ? ST_PRESCALE : ST_DONE;
        end
      end
      ST_PRESCALE: begin
        if (div_rsp.done) state_d = ST_ADVANCE;
      end
      ST_ADVANCE: begin
        state_d = (ticks_q != '0 && wrap_ge) ? ST_WRAP : ST_DONE;
      end
      ST_WRAP: begin
        if (div_rsp.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = wrap_diff;
    div_req.divisor  = DIV_W'(period);
    case (state_q)
      ST_IDLE: begin
        div_req.start    = accept && (op_i == OP_TICK) && tick_run;
        div_req.dividend = {1'b0, cycles_i} + DIV_W'(accum_q);
        div_req.divisor  = DIV_W'({1'b0, psc_q} + 17'd1);
      end
      ST_ADVANCE: begin
        div_req.start = (ticks_q != '0) && wrap_ge;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // register file and tick datapath
  always_comb begin
    ctrl_d      = ctrl_q;
    dier_d      = dier_q;
    uif_d       = uif_q;
    counter_d   = counter_q;
    psc_d       = psc_q;
    reload_d    = reload_q;
    accum_d     = accum_q;
    cnt_clamp_d = cnt_clamp_q;
    thr_d       = thr_q;
    ticks_d     = ticks_q;
    res_rdata_d = res_rdata_q;
    res_berr_d  = res_berr_q;
    res_irq_d   = res_irq_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_rdata_d = '0;
          res_berr_d  = 1'b0;
          res_irq_d   = 1'b0;
          cnt_clamp_d = cnt_clamp;
          // distance to the next wrap, counting the wrap step itself
          if (ctrl_q[BIT_DIR]) begin
            thr_d = {1'b0, cnt_clamp} + 1'b1;
          end else begin
            thr_d = {1'b0, reload_q} - {1'b0, cnt_clamp} + 1'b1;
          end
          if (op_i == OP_READ || op_i == OP_WRITE) begin
            if (!size_ok) begin
              res_berr_d = 1'b1;
            end else if (!blocked && acc.hit) begin
              if (op_i == OP_READ) begin
                res_rdata_d = rd32;
              end else begin
                case (acc.sel)
                  REG_CR1:  ctrl_d    = merged32[15:0];
                  REG_DIER: dier_d    = merged32[15:0];
                  REG_SR: begin
                    // a written zero clears the flag
                    if (acc.lane[0] && !wdata_i[0]) uif_d = 1'b0;
                  end
                  REG_EGR: begin
                    if (acc.lane[BIT_UG] && wdata_i[BIT_UG]) begin
                      counter_d = '0;
                      accum_d   = '0;
                      if (!ctrl_q[BIT_UDIS]) begin
                        uif_d     = 1'b1;
                        res_irq_d = dier_q[BIT_UIE];
                        if (ctrl_q[BIT_OPM]) ctrl_d[BIT_CEN] = 1'b0;
                      end
                    end
                  end
                  REG_CNT:  counter_d = merged32[CW-1:0];
                  REG_PSC:  psc_d     = merged32[15:0];
                  REG_ARR:  reload_d  = merged32[CW-1:0];
                  default:  ctrl_d    = ctrl_q;
                endcase
              end
            end
          end
        end
      end
      ST_PRESCALE: begin
        if (div_rsp.done) begin
          accum_d = div_rsp.remainder[15:0];
          ticks_d = div_rsp.quotient;
        end
      end
      ST_ADVANCE: begin
        // no wrap: step the counter directly
        if (ticks_q != '0 && !wrap_ge) begin
          if (ctrl_q[BIT_DIR]) begin
            counter_d = cnt_clamp_q - ticks_q[CW-1:0];
          end else begin
            counter_d = cnt_clamp_q + ticks_q[CW-1:0];
          end
        end
      end
      ST_WRAP: begin
        if (div_rsp.done) begin
          if (ctrl_q[BIT_DIR]) begin
            counter_d = (div_rsp.remainder[CW-1:0] == '0) ? reload_q
                      : reload_q - div_rsp.remainder[CW-1:0];
          end else begin
            counter_d = div_rsp.remainder[CW-1:0];
          end
          if (!ctrl_q[BIT_UDIS]) begin
            uif_d     = 1'b1;
            res_irq_d = dier_q[BIT_UIE];
            if (ctrl_q[BIT_OPM]) ctrl_d[BIT_CEN] = 1'b0;
          end
        end
      end
      default: begin
        ticks_d = ticks_q;
      end
    endcase
  end

  // control state and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      secure_q    <= 1'b0;
      clken_q     <= 1'b1;
      ctrl_q      <= '0;
      dier_q      <= '0;
      uif_q       <= 1'b0;
      counter_q   <= '0;
      psc_q       <= '0;
      reload_q    <= '1;
      accum_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ctrl_q    <= ctrl_d;
      dier_q    <= dier_d;
      uif_q     <= uif_d;
      counter_q <= counter_d;
      psc_q     <= psc_d;
      reload_q  <= reload_d;
      accum_q   <= accum_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SECURE_LOCK: secure_q <= cfg_wdata_i[0];
          CFG_CLOCK_EN:    clken_q  <= cfg_wdata_i[0];
          default:         secure_q <= secure_q;
        endcase
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    cnt_clamp_q <= cnt_clamp_d;
    thr_q       <= thr_d;
    ticks_q     <= ticks_d;
    res_rdata_q <= res_rdata_d;
    res_berr_q  <= res_berr_d;
    res_irq_q   <= res_irq_d;
    if (state_q == ST_DONE && out_free) begin
      out_rdata_q <= res_rdata_q;
      out_berr_q  <= res_berr_q;
      out_irq_q   <= res_irq_q;
      out_uif_q   <= uif_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rdata_o       = out_rdata_q;
  assign bus_error_o   = out_berr_q;
  assign irq_pulse_o   = out_irq_q;
  assign update_flag_o = out_uif_q;

  // divider answers only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_PRESCALE || state_q == ST_WRAP))
    else $error("divider done outside a divide state");

  // an interrupt pulse always comes with the update flag set
  a_irq_has_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && irq_pulse_o |-> update_flag_o)
    else $error("irq pulse without update flag");

  // a finished word waits while the output register is held
  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_valid_q && out_stall_i |=> state_q == ST_DONE)
    else $error("result left done state while output stalled");

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timer register block. Tick, read and write
// words go in under random gaps and stalls, a timer model inside the bench
// works out each result word, and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_top
  import gpt_pkg::*;
();

  localparam logic [1:0]  OP_NONE         = 2'd3;
  localparam int unsigned UIF_BIT         = 0;
  localparam int          DRAIN_CYCLES    = 80;
  localparam int          IDLE_LIMIT      = 3000;
  localparam int          WORDS_PER_PHASE = 305;
  localparam int          NUM_PHASES      = 6;
  localparam logic [5:0]  SECURE_PLAN     = 6'b010101;
  localparam logic [5:0]  CLKEN_PLAN      = 6'b111001;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  offset;
    logic [2:0]  size;
    logic [31:0] wdata;
    logic [31:0] cycles;
    logic        nonsecure;
  } bus_word_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        bus_error;
    logic        irq_pulse;
    logic        update_flag;
  } reply_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  out_stall_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  bus_word_t             drv_word    = '0;

  wire        in_stall_o;
  wire        out_valid_o;
  wire [31:0] rdata_o;
  wire        bus_error_o;
  wire        irq_pulse_o;
  wire        update_flag_o;
  wire        cfg_ready_o;

  bus_word_t word_q[$];
  reply_t    reply_q[$];

  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;
  int          mismatches  = 0;
  bit          quiet       = 1'b0;
  bit          word_taken  = 1'b0;

  // timer model state
  logic [15:0] ctrl_q;
  logic [15:0] ier_q;
  logic [15:0] stat_q;
  logic [31:0] cnt_q;
  logic [15:0] psc_q;
  logic [31:0] arr_q;
  logic [15:0] acc_q;
  logic        sec_only_q;
  logic        clk_en_q;
  logic        upd_irq;

  general_purpose_timer_regs #(
    .COUNTER_WIDTH(32)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (drv_word.op),
    .offset_i     (drv_word.offset),
    .size_bytes_i (drv_word.size),
    .wdata_i      (drv_word.wdata),
    .cycles_i     (drv_word.cycles),
    .nonsecure_i  (drv_word.nonsecure),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rdata_o      (rdata_o),
    .bus_error_o  (bus_error_o),
    .irq_pulse_o  (irq_pulse_o),
    .update_flag_o(update_flag_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void reset_model();
    ctrl_q     = '0;
    ier_q      = '0;
    stat_q     = '0;
    cnt_q      = '0;
    psc_q      = '0;
    arr_q      = '1;
    acc_q      = '0;
    sec_only_q = 1'b0;
    clk_en_q   = 1'b1;
    upd_irq    = 1'b0;
  endfunction

  function automatic logic [31:0] byte_mask(int unsigned sz);
    return (sz >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (sz * 8)) - 32'd1);
  endfunction

  function automatic logic [9:0] reg_offset(int unsigned idx);
    case (reg_e'(idx))
      REG_CR1:  return OFS_CR1;
      REG_DIER: return OFS_DIER;
      REG_SR:   return OFS_SR;
      REG_EGR:  return OFS_EGR;
      REG_CNT:  return OFS_CNT;
      REG_PSC:  return OFS_PSC;
      default:  return OFS_ARR;
    endcase
  endfunction

  // register that wholly holds the access, or -1
  function automatic int reg_lookup(logic [9:0] ofs, logic [2:0] sz);
    for (int i = 0; i < 7; i++) begin
      if (ofs >= reg_offset(i) && int'(ofs) + int'(sz) <= int'(reg_offset(i)) + 4) return i;
    end
    return -1;
  endfunction

  // update event: flag, interrupt and one-pulse stop, unless disabled
  function automatic void raise_update();
    if (ctrl_q[BIT_UDIS]) return;
    stat_q[UIF_BIT] = 1'b1;
    if (ier_q[BIT_UIE]) upd_irq = 1'b1;
    if (ctrl_q[BIT_OPM]) ctrl_q[BIT_CEN] = 1'b0;
  endfunction

  // prescaler then up/down counter, any number of wraps per tick
  function automatic void count_ticks(logic [31:0] cycles);
    longint unsigned divisor, total, steps, top, pos, period, rem;
    logic wrapped;
    wrapped = 1'b0;
    if (!ctrl_q[BIT_CEN] || !clk_en_q) return;
    divisor = 64'(psc_q) + 64'd1;
    total   = 64'(acc_q) + 64'(cycles);
    acc_q   = 16'(total % divisor);
    steps   = total / divisor;
    if (steps == 0) return;
    top    = 64'(arr_q);
    pos    = 64'(cnt_q);
    period = top + 64'd1;
    if (pos > top) pos = top;
    if (ctrl_q[BIT_DIR]) begin
      if (steps >= pos + 64'd1) begin
        wrapped = 1'b1;
        rem = (steps - (pos + 64'd1)) % period;
        pos = (rem == 0) ? top : top - rem;
      end else begin
        pos = pos - steps;
      end
    end else begin
      if (steps >= top - pos + 64'd1) begin
        wrapped = 1'b1;
        pos = (steps - (top - pos + 64'd1)) % period;
      end else begin
        pos = pos + steps;
      end
    end
    cnt_q = pos[31:0];
    if (wrapped) raise_update();
  endfunction

  function automatic logic [31:0] reg_read(logic [9:0] ofs, logic [2:0] sz);
    int          r;
    int unsigned sh;
    logic [31:0] v;
    r = reg_lookup(ofs, sz);
    if (r < 0) return 32'h0;
    sh = (int'(ofs) - int'(reg_offset(r))) * 8;
    case (reg_e'(r))
      REG_CR1:  v = 32'(ctrl_q);
      REG_DIER: v = 32'(ier_q);
      REG_SR:   v = 32'(stat_q);
      REG_CNT:  v = cnt_q;
      REG_PSC:  v = 32'(psc_q);
      REG_ARR:  v = arr_q;
      default:  v = 32'h0;
    endcase
    return (v >> sh) & byte_mask(sz);
  endfunction

  function automatic void reg_write(logic [9:0] ofs, logic [2:0] sz, logic [31:0] val);
    int          r;
    int unsigned sh;
    logic [31:0] m, lanes, keep, clr, tmp;
    r = reg_lookup(ofs, sz);
    if (r < 0) return;
    sh    = (int'(ofs) - int'(reg_offset(r))) * 8;
    m     = byte_mask(sz);
    lanes = (val & m) << sh;
    keep  = ~(m << sh);
    case (reg_e'(r))
      REG_CR1: begin
        tmp = (32'(ctrl_q) & keep) | lanes;
        ctrl_q = tmp[15:0];
      end
      REG_DIER: begin
        tmp = (32'(ier_q) & keep) | lanes;
        ier_q = tmp[15:0];
      end
      // written zeros clear, written ones keep
      REG_SR: begin
        clr = (m << sh) & ~lanes;
        stat_q = stat_q & ~clr[15:0];
      end
      REG_EGR: begin
        if (lanes[BIT_UG]) begin
          cnt_q = '0;
          acc_q = '0;
          raise_update();
        end
      end
      REG_CNT: cnt_q = (cnt_q & keep) | lanes;
      REG_PSC: begin
        tmp = (32'(psc_q) & keep) | lanes;
        psc_q = tmp[15:0];
      end
      default: arr_q = (arr_q & keep) | lanes;
    endcase
  endfunction

  // expected result word of one accepted word
  function automatic reply_t apply_word(bus_word_t w);
    reply_t rep;
    rep = '0;
    upd_irq = 1'b0;
    case (w.op)
      OP_TICK: count_ticks(w.cycles);
      OP_READ, OP_WRITE: begin
        // size check comes before the security check
        if (w.size == 3'd0 || w.size > 3'd4) begin
          rep.bus_error = 1'b1;
        end else if (!(sec_only_q && w.nonsecure)) begin
          if (w.op == OP_READ) rep.rdata = reg_read(w.offset, w.size);
          else reg_write(w.offset, w.size, w.wdata);
        end
      end
      default: ;
    endcase
    rep.irq_pulse   = upd_irq;
    rep.update_flag = stat_q[UIF_BIT];
    return rep;
  endfunction

  function automatic bus_word_t word_of(logic [1:0] op, logic [9:0] ofs, logic [2:0] sz,
                                        logic [31:0] data, logic [31:0] cyc, logic ns);
    bus_word_t w;
    w.op        = op;
    w.offset    = ofs;
    w.size      = sz;
    w.wdata     = data;
    w.cycles    = cyc;
    w.nonsecure = ns;
    return w;
  endfunction

  // gap length: mostly none or short, a few long
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bus_word_t rand_word();
    bus_word_t   w;
    int unsigned pick, idx, sz;
    w.offset    = 10'($urandom_range(0, 1023));
    w.size      = 3'($urandom_range(0, 7));
    w.wdata     = $urandom();
    w.cycles    = $urandom();
    w.nonsecure = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 40) w.op = OP_TICK;
    else if (pick < 62) w.op = OP_READ;
    else if (pick < 97) w.op = OP_WRITE;
    else w.op = OP_NONE;
    if (w.op == OP_TICK) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) w.cycles = $urandom_range(0, 40);
      else if (pick < 85) w.cycles = $urandom_range(0, 2000);
    end else if ($urandom_range(0, 99) < 85) begin
      // mostly accesses that land inside one register
      idx  = $urandom_range(0, 6);
      pick = $urandom_range(0, 9);
      sz   = (pick < 5) ? 4 : (pick < 7) ? 2 : (pick < 9) ? 1 : 3;
      w.size   = 3'(sz);
      w.offset = reg_offset(idx) + 10'($urandom_range(0, 4 - sz));
      if ($urandom_range(0, 9) == 0) begin
        sz = $urandom_range(4, 7);
        w.size = (sz == 4) ? 3'd0 : 3'(sz);
      end
      // keep the timer running with short periods most of the time
      if (w.op == OP_WRITE && w.offset == reg_offset(idx)) begin
        case (reg_e'(idx))
          REG_CR1: begin
            if ($urandom_range(0, 9) < 8) w.wdata[BIT_CEN] = 1'b1;
            if ($urandom_range(0, 9) < 7) w.wdata[BIT_OPM] = 1'b0;
            if ($urandom_range(0, 9) < 8) w.wdata[BIT_UDIS] = 1'b0;
          end
          REG_PSC: if ($urandom_range(0, 3) != 0) w.wdata = $urandom_range(0, 7);
          REG_ARR: if ($urandom_range(0, 6) != 0) w.wdata = $urandom_range(0, 40);
          REG_CNT: if ($urandom_range(0, 1) != 0) w.wdata = $urandom_range(0, 60);
          default: ;
        endcase
      end
    end
    return w;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic bit_val);
    logic [CFG_DATA_W-1:0] data;
    data    = $urandom();
    data[0] = bit_val;
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_SECURE_LOCK) sec_only_q = bit_val;
    else clk_en_q = bit_val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // hold off until every word is sent and every result is back
  task automatic wait_drain();
    do @(posedge clk_i); while (word_q.size() != 0 || in_valid_i || reply_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // input word driver
  always @(negedge clk_i) begin
    if (!in_valid_i || word_taken) begin
      if (word_taken) begin
        word_taken = 1'b0;
        send_gap   = idle_len();
        if ($urandom_range(0, 99) == 0) quiet = !quiet;
      end
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (word_q.size() != 0) begin
        drv_word   <= word_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side stalls
  always @(negedge clk_i) begin
    if (stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = idle_len();
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // result checker and prediction on accepted words
  always @(posedge clk_i) begin
    reply_t want;
    if (out_valid_o && !out_stall_i) begin
      if (reply_q.size() == 0) begin
        $display("%0t: result word with nothing expected, rdata %h", $time, rdata_o);
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        check_field("rdata", want.rdata, rdata_o);
        check_field("bus_error", 32'(want.bus_error), 32'(bus_error_o));
        check_field("irq_pulse", 32'(want.irq_pulse), 32'(irq_pulse_o));
        check_field("update_flag", 32'(want.update_flag), 32'(update_flag_o));
      end
    end
    if (in_valid_i && !in_stall_o) begin
      reply_q.push_back(apply_word(drv_word));
      word_taken = 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    reset_model();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    cfg_write(CFG_SECURE_LOCK, 1'b0);
    cfg_write(CFG_CLOCK_EN, 1'b1);

    // directed words
    word_q.push_back(word_of(OP_READ, OFS_ARR, 3'd4, 32'h0, 32'h0, 1'b0));
    word_q.push_back(word_of(OP_TICK, 10'h0, 3'd0, 32'h0, 32'd100, 1'b0));
    word_q.push_back(word_of(OP_WRITE, OFS_CR1, 3'd0, 32'h1, 32'h0, 1'b0));
    word_q.push_back(word_of(OP_READ, OFS_CR1, 3'd7, 32'h0, 32'h0, 1'b0));
    word_q.push_back(word_of(OP_WRITE, OFS_PSC, 3'd2, 32'h2, 32'h0, 1'b0));
    word_q.push_back(word_of(OP_WRITE, OFS_ARR, 3'd4, 32'h4, 32'h0, 1'b0));
    word_q.push_back(word_of(OP_WRITE, OFS_DIER, 3'd1, 32'h1, 32'h0, 1'b1));
    word_q.push_back(word_of(OP_WRITE, OFS_CR1, 3'd1, 32'd1 << BIT_CEN, 32'h0, 1'b0));
    word_q.push_back(word_of(OP_TICK, 10'h0, 3'd0, 32'h0, 32'hFFFF_FFFF, 1'b0));
    word_q.push_back(word_of(OP_READ, OFS_SR, 3'd1, 32'h0, 32'h0, 1'b0));
    word_q.push_back(word_of(OP_WRITE, OFS_SR, 3'd1, 32'h0, 32'h0, 1'b0));
    // counter parked above the reload value
    word_q.push_back(word_of(OP_WRITE, OFS_CNT, 3'd4, 32'hFFFF_FFF0, 32'h0, 1'b0));
    word_q.push_back(word_of(OP_TICK, 10'h0, 3'd0, 32'h0, 32'd3, 1'b0));
    word_q.push_back(word_of(OP_WRITE, OFS_CR1, 3'd2,
                             (32'd1 << BIT_CEN) | (32'd1 << BIT_DIR), 32'h0, 1'b0));
    word_q.push_back(word_of(OP_TICK, 10'h0, 3'd0, 32'h0, 32'd20, 1'b0));
    word_q.push_back(word_of(OP_WRITE, OFS_EGR, 3'd1, 32'hFFFF_FF01, 32'h0, 1'b0));
    // update disabled: no wrap event and no software update
    word_q.push_back(word_of(OP_WRITE, OFS_CR1, 3'd1,
                             (32'd1 << BIT_CEN) | (32'd1 << BIT_UDIS), 32'h0, 1'b0));
    word_q.push_back(word_of(OP_TICK, 10'h0, 3'd0, 32'h0, 32'd100, 1'b0));
    word_q.push_back(word_of(OP_WRITE, OFS_EGR, 3'd4, 32'h1, 32'h0, 1'b0));
    // one-pulse mode stops the counter at the first update
    word_q.push_back(word_of(OP_WRITE, OFS_CR1, 3'd4,
                             32'hFFFF_0000 | (32'd1 << BIT_CEN) | (32'd1 << BIT_OPM),
                             32'h0, 1'b0));
    word_q.push_back(word_of(OP_TICK, 10'h0, 3'd0, 32'h0, 32'd50, 1'b0));
    word_q.push_back(word_of(OP_READ, OFS_CR1, 3'd2, 32'h0, 32'h0, 1'b0));
    // straddling and unmapped accesses
    word_q.push_back(word_of(OP_READ, 10'h00E, 3'd4, 32'h0, 32'h0, 1'b0));
    word_q.push_back(word_of(OP_WRITE, 10'h02E, 3'd4, 32'h0, 32'h0, 1'b0));
    word_q.push_back(word_of(OP_READ, 10'h3FF, 3'd1, 32'h0, 32'h0, 1'b0));
    word_q.push_back(word_of(OP_NONE, 10'h0, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    word_q.push_back(word_of(OP_READ, 10'h02D, 3'd2, 32'h0, 32'h0, 1'b0));
    wait_drain();

    // random phases over the security and clock enable settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      cfg_write(CFG_SECURE_LOCK, SECURE_PLAN[ph]);
      cfg_write(CFG_CLOCK_EN, CLKEN_PLAN[ph]);
      repeat (WORDS_PER_PHASE) word_q.push_back(rand_word());
      wait_drain();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
